@@ rtl/rsa_pkg.sv @@
// Shared constants and codes for the random-select slot allocator.
package rsa_pkg;

  localparam int unsigned SLOTS_DEF = 512;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned RC_W      = 10;
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned TDATA_IN_W  = 32;
  localparam int unsigned TDATA_OUT_W = 24;

  localparam logic [CFG_W-1:0] SLOT_COUNT_RST   = CFG_W'(512);
  localparam logic [CFG_W-1:0] MAX_RESIDENT_RST = CFG_W'(512);

  localparam logic REG_SLOT_COUNT   = 1'b0;
  localparam logic REG_MAX_RESIDENT = 1'b1;

  localparam logic OP_RELEASE = 1'b0;
  localparam logic OP_CLAIM   = 1'b1;

  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd2;

endpackage

@@ rtl/random_select_slot_allocator.sv @@
// Top level of the random-select slot allocator: slot memory, scan and control.
//
//  channel  | direction | handshake                    | content
//  s_axis   | in        | s_axis_tvalid_i/tready_o     | opcode (tuser), random_word (tdata)
//  m_axis   | out       | m_axis_tvalid_o/tready_i     | slot_index, status, reused, count
//  cfg      | in        | cfg_valid_i/cfg_ready_o      | register index, 10-bit value
//
// A claim or release that reaches the search passes from its accept through the remainder
// unit, the registered read of the slot memory, one memory row of 16 slots per cycle through
// the single read port, a state to locate and write back, a state to load the output
// register and the return to idle. A refused item or one with no candidate goes straight
// to the state that loads the output register.
// Reset clears the per-row valid bits at once, so no clearing pass is needed.
// A finished result waits in the output register; a new item is taken meanwhile.
module random_select_slot_allocator #(
  parameter int unsigned SLOTS = rsa_pkg::SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [31:0] random_word
  input  logic [rsa_pkg::TDATA_IN_W-1:0]  s_axis_tdata_i,
  // [0] opcode
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [8:0] slot_index, [10:9] status, [11] reused, [21:12] resident_count, [23:22] zero
  output logic [rsa_pkg::TDATA_OUT_W-1:0] m_axis_tdata_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [rsa_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int unsigned W     = rsa_pkg::ROW_W;
  localparam int unsigned LW    = $clog2(W);
  localparam int unsigned CNTW  = $clog2(W + 1);
  localparam int unsigned AW    = $clog2(SLOTS + 1);
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned R     = (SLOTS + W - 1) / W;
  localparam int unsigned RAW   = (R > 1) ? $clog2(R) : 1;
  localparam int unsigned CW    = (AW > rsa_pkg::CFG_W) ? AW : rsa_pkg::CFG_W;
  localparam int unsigned OW    = (AW > CNTW) ? AW : CNTW;
  localparam int unsigned BW0   = (RAW + LW > CW) ? RAW + LW : CW;
  localparam int unsigned BW    = BW0 + 1;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_LOC,
    ST_FIN
  } state_e;

  state_e state_q;

  logic [rsa_pkg::CFG_W-1:0] slot_cfg_q;
  logic [rsa_pkg::CFG_W-1:0] maxres_cfg_q;

  logic [AW-1:0]  act_q;
  logic           op_q;
  logic [BW-1:0]  lim_q;
  logic [AW-1:0]  ord_q;
  logic [RAW-1:0] rd_row_q;
  logic [RAW-1:0] ev_row_q;
  logic           pend_q;
  logic           last_iss_q;
  logic [R-1:0]   row_vld_q;
  logic [RAW-1:0] hit_row_q;
  logic [W-1:0]   cand_q;
  logic [W-1:0]   row_act_q;
  logic [W-1:0]   row_used_q;

  logic [SW-1:0]                 res_idx_q;
  logic [rsa_pkg::STAT_W-1:0]    res_stat_q;
  logic                          res_reuse_q;

  logic                           m_valid_q;
  logic [rsa_pkg::TDATA_OUT_W-1:0] m_data_q;

  logic [2*W-1:0] mem [R];
  logic [2*W-1:0] rdata_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_cfg_q   <= rsa_pkg::SLOT_COUNT_RST;
      maxres_cfg_q <= rsa_pkg::MAX_RESIDENT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == rsa_pkg::REG_SLOT_COUNT) begin
        slot_cfg_q <= cfg_data_i;
      end else begin
        maxres_cfg_q <= cfg_data_i;
      end
    end
  end

  // Admission checks at accept time.
  logic          accept;
  logic [CW-1:0] n_slots;
  logic [CW-1:0] act_w;
  logic [CW-1:0] free_cnt;
  logic          refused;
  logic          no_cand;
  logic [AW-1:0] divisor;
  logic          mod_start;
  logic          mod_done;
  logic [AW-1:0] mod_rem;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    act_w    = CW'(act_q);
    n_slots  = (CW'(slot_cfg_q) > SLOTS_C) ? SLOTS_C : CW'(slot_cfg_q);
    free_cnt = (n_slots > act_w) ? n_slots - act_w : '0;
    refused  = (s_axis_tuser_i == rsa_pkg::OP_CLAIM) && (act_w >= CW'(maxres_cfg_q));
    if (s_axis_tuser_i == rsa_pkg::OP_CLAIM) begin
      no_cand = (free_cnt == '0);
      divisor = AW'(free_cnt);
    end else begin
      no_cand = (act_q == '0);
      divisor = act_q;
    end
  end

  assign mod_start = accept && !refused && !no_cand;

  rsa_mod #(
    .DIV_W(AW)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(s_axis_tdata_i[rsa_pkg::WORD_W-1:0]),
    .divisor_i (divisor),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  // Row evaluation during the scan.
  logic [W-1:0]    ev_act;
  logic [W-1:0]    ev_used;
  logic [W-1:0]    lim_mask;
  logic [W-1:0]    ev_cand;
  logic [CNTW-1:0] ev_cnt;
  logic [OW-1:0]   ord_ext;
  logic [OW-1:0]   cnt_ext;
  logic            ev_hit;
  logic            rd_en;

  always_comb begin
    ev_act  = row_vld_q[ev_row_q] ? rdata_q[W-1:0] : '0;
    ev_used = row_vld_q[ev_row_q] ? rdata_q[2*W-1:W] : '0;
    for (int j = 0; j < W; j++) begin
      lim_mask[j] = BW'({ev_row_q, LW'(j)}) < lim_q;
    end
    ev_cand = ((op_q == rsa_pkg::OP_CLAIM) ? ~ev_act : ev_act) & lim_mask;
    ev_cnt  = CNTW'($countones(ev_cand));
    ord_ext = OW'(ord_q);
    cnt_ext = OW'(ev_cnt);
    ev_hit  = ord_ext < cnt_ext;
  end

  assign rd_en = (state_q == ST_SCAN) && !last_iss_q;

  // Locating the chosen slot inside the hit row.
  logic [W-1:0]    sel;
  logic [LW-1:0]   sel_pos;
  logic [CNTW-1:0] pre_cnt;
  logic [W-1:0]    new_act;
  logic [W-1:0]    new_used;
  logic [RAW+LW-1:0] slot_full;

  always_comb begin
    sel     = '0;
    sel_pos = '0;
    pre_cnt = '0;
    for (int j = 0; j < W; j++) begin
      pre_cnt = CNTW'($countones(cand_q & ((W'(1) << j) - W'(1))));
      sel[j]  = cand_q[j] && (OW'(pre_cnt) == ord_ext);
    end
    for (int j = 0; j < W; j++) begin
      if (sel[j]) begin
        sel_pos = sel_pos | LW'(j);
      end
    end
    new_act   = row_act_q ^ sel;
    new_used  = (op_q == rsa_pkg::OP_CLAIM) ? (row_used_q | sel) : row_used_q;
    slot_full = {hit_row_q, sel_pos};
  end

  // Slot memory: one row of active and used bits per address.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOC) begin
      mem[hit_row_q] <= {new_used, new_act};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_row_q];
    end
  end

  // Output field packing.
  logic [AW+rsa_pkg::RC_W-1:0]  rc_ext;
  logic [SW+rsa_pkg::IDX_W-1:0] idx_ext;

  assign rc_ext  = (AW + rsa_pkg::RC_W)'(act_q);
  assign idx_ext = (SW + rsa_pkg::IDX_W)'(res_idx_q);

  // Control sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      act_q       <= '0;
      row_vld_q   <= '0;
      pend_q      <= 1'b0;
      last_iss_q  <= 1'b0;
      m_valid_q   <= 1'b0;
      op_q        <= rsa_pkg::OP_RELEASE;
      lim_q       <= '0;
      ord_q       <= '0;
      rd_row_q    <= '0;
      ev_row_q    <= '0;
      hit_row_q   <= '0;
      cand_q      <= '0;
      row_act_q   <= '0;
      row_used_q  <= '0;
      res_idx_q   <= '0;
      res_stat_q  <= rsa_pkg::STAT_DONE;
      res_reuse_q <= 1'b0;
      m_data_q    <= '0;
    end else begin
      if (m_valid_q && m_axis_tready_i && state_q != ST_FIN) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q        <= s_axis_tuser_i;
            lim_q       <= (s_axis_tuser_i == rsa_pkg::OP_CLAIM) ? BW'(n_slots) : BW'(SLOTS_C);
            res_idx_q   <= '0;
            res_reuse_q <= 1'b0;
            if (refused) begin
              res_stat_q <= rsa_pkg::STAT_REFUSED;
              state_q    <= ST_FIN;
            end else if (no_cand) begin
              res_stat_q <= rsa_pkg::STAT_EMPTY;
              state_q    <= ST_FIN;
            end else begin
              res_stat_q <= rsa_pkg::STAT_EMPTY;
              state_q    <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            ord_q      <= mod_rem;
            rd_row_q   <= '0;
            pend_q     <= 1'b0;
            last_iss_q <= 1'b0;
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend_q   <= rd_en;
          ev_row_q <= rd_row_q;
          if (rd_en) begin
            rd_row_q   <= rd_row_q + RAW'(1);
            last_iss_q <= (rd_row_q == RAW'(R - 1));
          end
          if (pend_q) begin
            if (ev_hit) begin
              hit_row_q  <= ev_row_q;
              cand_q     <= ev_cand;
              row_act_q  <= ev_act;
              row_used_q <= ev_used;
              state_q    <= ST_LOC;
            end else if (ev_row_q == RAW'(R - 1)) begin
              state_q <= ST_FIN;
            end else begin
              ord_q <= AW'(ord_ext - cnt_ext);
            end
          end
        end
        ST_LOC: begin
          row_vld_q[hit_row_q] <= 1'b1;
          res_idx_q  <= SW'(slot_full);
          res_stat_q <= rsa_pkg::STAT_DONE;
          if (op_q == rsa_pkg::OP_CLAIM) begin
            res_reuse_q <= |(row_used_q & sel);
            act_q       <= act_q + AW'(1);
          end else begin
            act_q <= act_q - AW'(1);
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= rsa_pkg::TDATA_OUT_W'({rc_ext[rsa_pkg::RC_W-1:0], res_reuse_q,
                                                res_stat_q, idx_ext[rsa_pkg::IDX_W-1:0]});
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_act_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(act_q) <= SLOTS_C)
    else $error("resident count above table size");

  a_locate_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOC) |-> $onehot(sel))
    else $error("locate did not pick exactly one slot");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOC) |=> (act_q != $past(act_q)))
    else $error("resident count unchanged after a done item");

  a_scan_has_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && pend_q && ev_hit |-> (ev_cand != '0))
    else $error("scan hit on a row without candidates");

endmodule

@@ rtl/rsa_mod.sv @@
// Iterative restoring remainder unit: one quotient bit per cycle.
module rsa_mod #(
  parameter int unsigned DIV_W = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rsa_pkg::WORD_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]           divisor_i,
  output logic                       done_o,
  output logic [DIV_W-1:0]           rem_o
);

  localparam int unsigned CNT_W = $clog2(rsa_pkg::WORD_W);

  logic                       busy_q;
  logic                       done_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [rsa_pkg::WORD_W-1:0] quo_q;
  logic [DIV_W-1:0]           rem_q;
  logic [DIV_W-1:0]           div_q;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;

  always_comb begin
    trial = {rem_q, quo_q[rsa_pkg::WORD_W-1]};
    ge    = trial >= {1'b0, div_q};
    diff  = trial - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(rsa_pkg::WORD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[rsa_pkg::WORD_W-2:0], 1'b0};
      rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q))
    else $error("remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("done without a finished division");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the random-select slot allocator with a slot-map predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_SLOTS = rsa_pkg::SLOTS_DEF;
  localparam int unsigned WORD_W = rsa_pkg::WORD_W;
  localparam int unsigned IDX_W = rsa_pkg::IDX_W;
  localparam int unsigned STAT_W = rsa_pkg::STAT_W;
  localparam int unsigned RC_W = rsa_pkg::RC_W;
  localparam int unsigned CFG_W = rsa_pkg::CFG_W;
  localparam int unsigned TDATA_IN_W = rsa_pkg::TDATA_IN_W;
  localparam int unsigned TDATA_OUT_W = rsa_pkg::TDATA_OUT_W;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES = 500;

  typedef struct {
    logic              op;
    logic [WORD_W-1:0] word;
  } alloc_req_t;

  typedef struct {
    logic [IDX_W-1:0]  slot;
    logic [STAT_W-1:0] status;
    logic              reused;
    logic [RC_W-1:0]   resident;
  } alloc_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDATA_IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  alloc_req_t    pending_reqs[$];
  alloc_result_t expected_results[$];
  bit            req_on_bus = 1'b0;
  bit            steady = 1'b0;
  bit            hold_req = 1'b0;
  bit            hold_ack = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   cycle_count = 0;
  int unsigned   error_count = 0;

  bit [TABLE_SLOTS-1:0] live_map = '0;
  bit [TABLE_SLOTS-1:0] ever_map = '0;
  int unsigned live_total = 0;
  int unsigned slot_count_q = 512;
  int unsigned max_res_q = 512;

  random_select_slot_allocator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned find_nth_slot(int unsigned limit, bit want,
                                                int unsigned ordinal);
    int unsigned left;
    left = ordinal;
    for (int unsigned i = 0; i < limit; i++) begin
      if (live_map[i] == want) begin
        if (left == 0) return i;
        left--;
      end
    end
    return limit;
  endfunction

  function automatic alloc_result_t allocate_slot(logic op, logic [WORD_W-1:0] word);
    alloc_result_t r;
    int unsigned n;
    int unsigned free_cnt;
    int unsigned s;
    r.slot = '0;
    r.status = rsa_pkg::STAT_EMPTY;
    r.reused = 1'b0;
    if (op == rsa_pkg::OP_CLAIM) begin
      n = (slot_count_q > TABLE_SLOTS) ? TABLE_SLOTS : slot_count_q;
      if (live_total >= max_res_q) begin
        r.status = rsa_pkg::STAT_REFUSED;
      end else begin
        free_cnt = (live_total < n) ? n - live_total : 0;
        if (free_cnt != 0) begin
          s = find_nth_slot(n, 1'b0, word % free_cnt);
          if (s < n) begin
            r.reused = ever_map[s];
            live_map[s] = 1'b1;
            ever_map[s] = 1'b1;
            live_total++;
            r.slot = IDX_W'(s);
            r.status = rsa_pkg::STAT_DONE;
          end
        end
      end
    end else if (live_total != 0) begin
      s = find_nth_slot(TABLE_SLOTS, 1'b1, word % live_total);
      if (s < TABLE_SLOTS) begin
        live_map[s] = 1'b0;
        live_total--;
        r.slot = IDX_W'(s);
        r.status = rsa_pkg::STAT_DONE;
      end
    end
    r.resident = RC_W'(live_total);
    return r;
  endfunction

  // Sender: holds an item until it is taken, then may idle before the next one.
  always @(posedge clk_i) begin
    alloc_req_t req;
    if (s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(allocate_slot(s_axis_tuser, s_axis_tdata));
      req_on_bus = 1'b0;
    end
    if (!req_on_bus) begin
      if (rst_ni && pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
        req = pending_reqs.pop_front();
        req_on_bus = 1'b1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= req.word;
        s_axis_tuser <= req.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started by toggling hold_req.
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack <= hold_req;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks each result item against the oldest prediction.
  always @(posedge clk_i) begin
    alloc_result_t got;
    alloc_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.slot = m_axis_tdata[8:0];
      got.status = m_axis_tdata[10:9];
      got.reused = m_axis_tdata[11];
      got.resident = m_axis_tdata[21:12];
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("result error %0d: unexpected item slot=%0d status=%0d", error_count,
                   got.slot, got.status);
      end else begin
        want = expected_results.pop_front();
        if (got.slot !== want.slot || got.status !== want.status ||
            got.reused !== want.reused || got.resident !== want.resident) begin
          error_count++;
          if (error_count <= 10)
            $display({"result error %0d: exp slot=%0d status=%0d reused=%0d count=%0d,",
                      " got slot=%0d status=%0d reused=%0d count=%0d"},
                     error_count, want.slot, want.status, want.reused, want.resident,
                     got.slot, got.status, got.reused, got.resident);
        end
      end
    end
    m_axis_tready <= rst_ni && hold_left == 0 && (steady || $urandom_range(99) >= 27);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("random_select_slot_allocator: mismatch");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return WORD_W'($urandom_range(31));
      3: return WORD_W'(1) << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_req(logic op, logic [WORD_W-1:0] word);
    alloc_req_t req;
    req.op = op;
    req.word = word;
    pending_reqs.push_back(req);
  endtask

  task automatic queue_random(int unsigned count, int unsigned claim_pct);
    for (int unsigned i = 0; i < count; i++)
      queue_req(($urandom_range(99) < claim_pct) ? rsa_pkg::OP_CLAIM : rsa_pkg::OP_RELEASE,
                pick_word());
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || req_on_bus || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_limits(int unsigned sc, int unsigned mr);
    for (int k = 0; k < 2; k++) begin
      @(posedge clk_i);
      cfg_valid <= 1'b1;
      cfg_index <= (k == 0) ? rsa_pkg::REG_SLOT_COUNT : rsa_pkg::REG_MAX_RESIDENT;
      cfg_data <= CFG_W'((k == 0) ? sc : mr);
      do @(posedge clk_i); while (!cfg_ready);
      cfg_valid <= 1'b0;
      if (k == 0) slot_count_q = sc & 32'h3FF;
      else max_res_q = mr & 32'h3FF;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_req(rsa_pkg::OP_RELEASE, '0);
    queue_req(rsa_pkg::OP_CLAIM, '0);
    queue_req(rsa_pkg::OP_CLAIM, '1);
    queue_req(rsa_pkg::OP_CLAIM, 32'd1);
    queue_req(rsa_pkg::OP_RELEASE, '0);
    queue_req(rsa_pkg::OP_CLAIM, '0);
    queue_req(rsa_pkg::OP_CLAIM, 32'd7);
    queue_req(rsa_pkg::OP_RELEASE, '1);
    queue_req(rsa_pkg::OP_CLAIM, '1);
    queue_req(rsa_pkg::OP_RELEASE, 32'd2);
    queue_req(rsa_pkg::OP_RELEASE, '0);
    drain();

    set_limits(0, 10);
    queue_req(rsa_pkg::OP_CLAIM, '0);
    queue_req(rsa_pkg::OP_CLAIM, '1);
    queue_req(rsa_pkg::OP_RELEASE, '1);
    drain();

    set_limits(300, 0);
    queue_req(rsa_pkg::OP_CLAIM, 32'd5);
    queue_req(rsa_pkg::OP_RELEASE, '0);
    queue_req(rsa_pkg::OP_CLAIM, '1);
    drain();

    set_limits(20, 5);
    for (int i = 0; i < 8; i++) queue_req(rsa_pkg::OP_CLAIM, pick_word());
    drain();

    set_limits(1023, 1023);
    queue_random(560, 96);
    drain();

    set_limits(16, 512);
    queue_random(110, 40);
    drain();

    set_limits(8, 8);
    hold_req <= ~hold_req;
    queue_random(120, 50);
    drain();

    set_limits(1, 1);
    steady <= 1'b1;
    queue_random(60, 50);
    drain();
    steady <= 1'b0;

    set_limits(512, 512);
    queue_random(100, 50);
    drain();

    for (int p = 0; p < 5; p++) begin
      set_limits($urandom_range(64), $urandom_range(70));
      queue_random(80, 60);
      drain();
    end

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("random_select_slot_allocator: match");
    end else begin
      $display("random_select_slot_allocator: mismatch");
    end
    $finish;
  end

endmodule
